FILE: rtl/bptc_pkg.sv
// package for the baro pressure/temperature compensation block
// holds shared types, constants and the shift helper; no dependencies
package bptc_pkg;

    localparam logic [2:0] CFG_A    = 3'd0;
    localparam logic [2:0] CFG_B    = 3'd1;
    localparam logic [2:0] CFG_C    = 3'd2;
    localparam logic [2:0] CFG_LAST = 3'd3;
    localparam logic [2:0] CFG_VAR  = 3'd4;

    // number of register stages in the datapath
    localparam int PIPE_DEPTH = 14;

    typedef struct packed {
        logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
        logic [31:0] kt, k5, k4, k8, k7;
    } coef_t;

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        sra = 32'($signed(x) >>> n);
    endfunction

endpackage

FILE: rtl/bptc_coef.sv
// coefficient unpacking from calibration words
// depends on bptc_pkg
module bptc_coef (
    input  logic [47:0]    cal_a,
    input  logic [47:0]    cal_b,
    input  logic [47:0]    cal_c,
    input  logic [15:0]    cal_last,
    input  logic           variant,
    output bptc_pkg::coef_t coef
);
    logic [31:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;

    always_comb
    begin
        r0 = {16'd0, cal_a[47:32]}; r1 = {16'd0, cal_a[31:16]}; r2 = {16'd0, cal_a[15:0]};
        r3 = {16'd0, cal_b[47:32]}; r4 = {16'd0, cal_b[31:16]}; r5 = {16'd0, cal_b[15:0]};
        r6 = {16'd0, cal_c[47:32]}; r7 = {16'd0, cal_c[31:16]}; r8 = {16'd0, cal_c[15:0]};
        r9 = {16'd0, cal_last};
        coef.c0  = r0 >> 4;
        coef.c1  = ((r1 & 32'hFF00) >> 5) | (r2 & 32'd7);
        coef.c2  = ((r1 & 32'hFF) << 1) | (r4 & 32'd1);
        coef.c3  = r2 >> 3;
        coef.c5  = r4 >> 1;
        coef.c6  = r5 >> 3;
        coef.c8  = r7 >> 3;
        coef.c9  = r8 >> 2;
        coef.c10 = ((r9 & 32'hFF00) >> 6) | (r8 & 32'd3);
        coef.c11 = r9 & 32'hFF;
        if (variant)
        begin
            coef.c4 = (r3 << 2) | (r0 & 32'd3);
            coef.c7 = (r6 << 3) | (r5 & 32'd7);
            coef.c12 = ((r0 & 32'hC) << 1) | (r7 & 32'd7);
            coef.kt = 32'd4459; coef.k5 = 32'd4443; coef.k4 = 32'd120586;
            coef.k8 = 32'd7180; coef.k7 = 32'd166426;
        end
        else
        begin
            coef.c4 = (r3 << 1) | (r5 & 32'd1);
            coef.c7 = (r6 << 2) | ((r0 >> 2) & 32'd3);
            coef.c12 = ((r5 & 32'd6) << 2) | (r7 & 32'd7);
            coef.kt = 32'd4418; coef.k5 = 32'd0; coef.k4 = 32'd211288;
            coef.k8 = 32'd7209; coef.k7 = 32'd285594;
        end
    end
endmodule

FILE: rtl/bptc_datapath.sv
// pipelined compensation datapath, at most one multiply level per stage
// depends on bptc_pkg
module bptc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [23:0]     ut_in,
    input  logic [23:0]     up_in,
    input  bptc_pkg::coef_t coef,
    output logic            out_valid,
    output logic [31:0]     rp_out,
    output logic [31:0]     rt_out
);
    logic [bptc_pkg::PIPE_DEPTH-1:0] v_reg;
    // stage payload registers
    logic [31:0] dt1_reg, up1_reg;
    logic [31:0] dt2_reg, m01_reg, m02a_reg, m03a_reg, up2_reg;
    logic [31:0] dt3_reg, x01_3_reg, m02b_reg, m03b_reg, up3_reg;
    logic [31:0] x01_4_reg, x02_4_reg, m03c_reg, up4_reg;
    logic [31:0] rt5_reg, d2_5_reg, up5_reg;
    logic [31:0] rt6_reg, d2_6_reg, m11_reg, m12a_reg, m21_reg, m22a_reg, mcf_reg, up6_reg;
    logic [31:0] rt7_reg, x11_7_reg, m12b_reg, x21_7_reg, m22b_reg, cf7_reg, up7_reg;
    logic [31:0] rt8_reg, x13_8_reg, x23_8_reg, neg8_reg, cf8_reg, up8_reg;
    logic [31:0] rt9_reg, pp1_9_reg, m24_reg, m25_reg, neg9_reg, cf9_reg;
    logic [31:0] rt10_reg, pp1_10_reg, x26_10_reg, cf10_reg;
    logic [31:0] rt11_reg, m2_reg, m3_reg, cf11_reg;
    logic [31:0] rt12_reg, pp4_12_reg, m31_reg, m32a_reg;
    logic [31:0] rt13_reg, pp4_13_reg, x31_13_reg, m32b_reg;
    logic [31:0] rt14_reg, rp14_reg;
    logic [31:0] k7c, x22, x21;

    assign k7c = coef.c7 + coef.k7;
    assign x21 = bptc_pkg::sra(x21_7_reg, 10);
    assign x22 = bptc_pkg::sra(m22b_reg, 12);

    // one valid bit per payload stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[bptc_pkg::PIPE_DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dt1_reg <= bptc_pkg::sra({8'd0, ut_in} - 32'd8388608, 4) + (coef.c0 << 4);
            up1_reg <= {8'd0, up_in} - 32'd8388608;
            // s2
            dt2_reg  <= dt1_reg;
            m01_reg  <= (coef.c1 + coef.kt) * dt1_reg;
            m02a_reg <= (coef.c2 - 32'd256) * dt1_reg;
            m03a_reg <= coef.c3 * dt1_reg;
            up2_reg  <= up1_reg;
            // s3
            dt3_reg   <= dt2_reg;
            x01_3_reg <= bptc_pkg::sra(m01_reg, 1);
            m02b_reg  <= bptc_pkg::sra(m02a_reg, 14) * dt2_reg;
            m03b_reg  <= bptc_pkg::sra(m03a_reg, 18) * dt2_reg;
            up3_reg   <= up2_reg;
            // s4
            x01_4_reg <= x01_3_reg;
            x02_4_reg <= bptc_pkg::sra(m02b_reg, 4);
            m03c_reg  <= bptc_pkg::sra(m03b_reg, 18) * dt3_reg;
            up4_reg   <= up3_reg;
            // s5
            rt5_reg  <= bptc_pkg::sra(32'd81920000 - x01_4_reg - x02_4_reg - m03c_reg, 15);
            d2_5_reg <= bptc_pkg::sra(x01_4_reg + x02_4_reg + m03c_reg, 12);
            up5_reg  <= up4_reg;
            // s6
            rt6_reg  <= rt5_reg;
            d2_6_reg <= d2_5_reg;
            m11_reg  <= (coef.c5 - coef.k5) * d2_5_reg;
            m12a_reg <= coef.c6 * d2_5_reg;
            m21_reg  <= (coef.c8 + coef.k8) * d2_5_reg;
            m22a_reg <= coef.c9 * d2_5_reg;
            mcf_reg  <= coef.c12 * d2_5_reg;
            up6_reg  <= up5_reg;
            // s7
            rt7_reg   <= rt6_reg;
            x11_7_reg <= m11_reg;
            m12b_reg  <= bptc_pkg::sra(m12a_reg, 16) * d2_6_reg;
            x21_7_reg <= m21_reg;
            m22b_reg  <= bptc_pkg::sra(m22a_reg, 17) * d2_6_reg;
            cf7_reg   <= bptc_pkg::sra(32'd2097152 + mcf_reg, 3);
            up7_reg   <= up6_reg;
            // s8
            rt8_reg   <= rt7_reg;
            x13_8_reg <= bptc_pkg::sra(x11_7_reg + bptc_pkg::sra(m12b_reg, 2), 10)
                         + ((coef.c4 + coef.k4) << 4);
            x23_8_reg <= ($signed(x22) >= $signed(x21)) ? x22 - x21 : x21 - x22;
            neg8_reg  <= x22 - x21;
            cf8_reg   <= cf7_reg;
            up8_reg   <= up7_reg;
            // s9
            rt9_reg   <= rt8_reg;
            pp1_9_reg <= bptc_pkg::sra(up8_reg - x13_8_reg, 3);
            m24_reg   <= bptc_pkg::sra(x23_8_reg, 11) * k7c;
            m25_reg   <= (x23_8_reg & 32'h7FF) * k7c;
            neg9_reg  <= neg8_reg;
            cf9_reg   <= cf8_reg;
            // s10
            rt10_reg   <= rt9_reg;
            pp1_10_reg <= pp1_9_reg;
            x26_10_reg <= neg9_reg[31]
                ? bptc_pkg::sra(32'd0 - m24_reg - bptc_pkg::sra(m25_reg, 11), 11) + k7c
                : bptc_pkg::sra(m24_reg + bptc_pkg::sra(m25_reg, 11), 11) + k7c;
            cf10_reg   <= cf9_reg;
            // s11
            rt11_reg <= rt10_reg;
            m2_reg   <= bptc_pkg::sra(x26_10_reg, 11) * pp1_10_reg;
            m3_reg   <= (x26_10_reg & 32'h7FF) * pp1_10_reg;
            cf11_reg <= cf10_reg;
            // s12
            rt12_reg   <= rt11_reg;
            pp4_12_reg <= bptc_pkg::sra(m2_reg + bptc_pkg::sra(m3_reg, 11), 10);
            m31_reg    <= cf11_reg * coef.c10;
            m32a_reg   <= cf11_reg * coef.c11;
            // s13
            rt13_reg   <= rt12_reg;
            pp4_13_reg <= pp4_12_reg;
            x31_13_reg <= bptc_pkg::sra(bptc_pkg::sra(m31_reg, 17) * pp4_12_reg, 2);
            m32b_reg   <= bptc_pkg::sra(m32a_reg, 15) * pp4_12_reg;
            // s14
            rt14_reg <= rt13_reg;
            rp14_reg <= bptc_pkg::sra(x31_13_reg
                        + bptc_pkg::sra(m32b_reg, 18) * pp4_13_reg, 15)
                        + pp4_13_reg + 32'd99880;
        end
    end

    assign out_valid = v_reg[bptc_pkg::PIPE_DEPTH-1];
    assign rp_out = rp14_reg;
    assign rt_out = rt14_reg;
endmodule

FILE: rtl/baro_pressure_temp_compensation.sv
// top level of the barometric compensation block
// depends on bptc_pkg, bptc_coef, bptc_datapath
//
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//    calibration words and variant bit; write only while the pipe is empty
//  - in channel (in_valid/in_ready) takes one raw temperature/pressure pair
//    per transaction; out channel (out_valid/out_ready) gives one result
//  - each accepted pair passes through all datapath stages before output
//  - throughput: one transaction per cycle unless the output stalls; the
//    pipe advances as a unit, at most one 32x32 multiply level per stage
//  - a stalled receiver freezes all stages; in_ready drops only while the
//    last stage holds a result that is not taken
//  - reset clears all valid bits and the calibration registers to zero
module baro_pressure_temp_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [23:0]        raw_temperature,
    input  logic [23:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pressure_pa,
    output logic signed [31:0] temperature_centi
);
    logic [47:0] cal_a_reg, cal_b_reg, cal_c_reg;
    logic [15:0] cal_last_reg;
    logic        variant_reg;
    bptc_pkg::coef_t coef;
    logic        adv, pv;
    logic [31:0] rp, rt;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg    <= '0;
            cal_b_reg    <= '0;
            cal_c_reg    <= '0;
            cal_last_reg <= '0;
            variant_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bptc_pkg::CFG_A:    cal_a_reg    <= cfg_data;
                bptc_pkg::CFG_B:    cal_b_reg    <= cfg_data;
                bptc_pkg::CFG_C:    cal_c_reg    <= cfg_data;
                bptc_pkg::CFG_LAST: cal_last_reg <= cfg_data[15:0];
                bptc_pkg::CFG_VAR:  variant_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bptc_coef u_coef (
        .cal_a(cal_a_reg), .cal_b(cal_b_reg), .cal_c(cal_c_reg),
        .cal_last(cal_last_reg), .variant(variant_reg), .coef(coef)
    );

    // pipe moves when the last stage is empty or being drained
    assign adv      = !pv || out_ready;
    assign in_ready = adv;

    bptc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(in_valid && in_ready),
        .ut_in(raw_temperature), .up_in(raw_pressure),
        .coef(coef), .out_valid(pv), .rp_out(rp), .rt_out(rt)
    );

    assign out_valid         = pv;
    assign pressure_pa       = $signed(rp);
    assign temperature_centi = $signed(rt);
endmodule

FILE: rtl/bptc_checker.sv
// port-level checker for the compensation block, bound to the top level
// depends only on the top level ports
module bptc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pressure_pa
);
    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressure_pa))
        else $error("stalled result changed");
    // input is blocked only by an untaken result
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without stall");
    // a result only goes away once it has been taken
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped");
    // an offered input transaction stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input transaction withdrawn");
endmodule

bind baro_pressure_temp_compensation bptc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pressure_pa(pressure_pa)
);

FILE: tb/sv/tb_baro_pressure_temp_compensation.sv
// testbench for baro_pressure_temp_compensation: predicts pressure and temperature
// per raw reading pair and checks every result transaction in order
// depends on bptc_pkg (register indexes) and the block itself
module tb_baro_pressure_temp_compensation;

    typedef struct {
        logic [23:0] rt;
        logic [23:0] rp;
    } reading_t;

    typedef struct {
        logic [31:0] pa;
        logic [31:0] centi;
    } comp_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [47:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [23:0]        raw_temperature;
    logic [23:0]        raw_pressure;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pressure_pa;
    logic signed [31:0] temperature_centi;

    baro_pressure_temp_compensation u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_temperature   (raw_temperature),
        .raw_pressure      (raw_pressure),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pressure_pa       (pressure_pa),
        .temperature_centi (temperature_centi)
    );

    // local copy of the calibration registers
    logic [47:0] cal_a, cal_b, cal_c;
    logic [15:0] cal_last;
    logic        variant;

    reading_t pending_readings[$];
    comp_t    expected_comp[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches = 0;
    int cycle_count = 0;
    logic hold_go;
    logic hold_off;

    // arithmetic right shift at 32 bits
    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = $signed(x) >>> n;
    endfunction

    function automatic comp_t compensate(input reading_t rd);
        logic [31:0] w[10];
        logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
        logic [31:0] kt, k5, k4, k8, k7;
        logic [31:0] dt, x01, x02, x03, tcomp, dt2, x11, x12, x13, x21, x22, x23;
        logic [31:0] k7c, x24, x25, x26, pp1, pp2, pp3, pp4, cf, x31, x32, pcomp;
        logic [31:0] diff;
        comp_t res;
        w[0] = {16'd0, cal_a[47:32]}; w[1] = {16'd0, cal_a[31:16]};
        w[2] = {16'd0, cal_a[15:0]};
        w[3] = {16'd0, cal_b[47:32]}; w[4] = {16'd0, cal_b[31:16]};
        w[5] = {16'd0, cal_b[15:0]};
        w[6] = {16'd0, cal_c[47:32]}; w[7] = {16'd0, cal_c[31:16]};
        w[8] = {16'd0, cal_c[15:0]};
        w[9] = {16'd0, cal_last};
        c0 = w[0] >> 4;
        c1 = ((w[1] & 32'hFF00) >> 5) | (w[2] & 32'd7);
        c2 = ((w[1] & 32'hFF) << 1) | (w[4] & 32'd1);
        c3 = w[2] >> 3;
        c5 = w[4] >> 1;
        c6 = w[5] >> 3;
        c8 = w[7] >> 3;
        c9 = w[8] >> 2;
        c10 = ((w[9] & 32'hFF00) >> 6) | (w[8] & 32'd3);
        c11 = w[9] & 32'hFF;
        if (variant) begin
            c4 = (w[3] << 2) | (w[0] & 32'd3);
            c7 = (w[6] << 3) | (w[5] & 32'd7);
            c12 = ((w[0] & 32'hC) << 1) | (w[7] & 32'd7);
            kt = 4459; k5 = 4443; k4 = 120586; k8 = 7180; k7 = 166426;
        end else begin
            c4 = (w[3] << 1) | (w[5] & 32'd1);
            c7 = (w[6] << 2) | ((w[0] >> 2) & 32'd3);
            c12 = ((w[5] & 32'd6) << 2) | (w[7] & 32'd7);
            kt = 4418; k5 = 0; k4 = 211288; k8 = 7209; k7 = 285594;
        end
        dt = asr({8'd0, rd.rt} - 32'd8388608, 4) + (c0 << 4);
        x01 = asr((c1 + kt) * dt, 1);
        x02 = asr(asr((c2 - 32'd256) * dt, 14) * dt, 4);
        x03 = asr(asr(c3 * dt, 18) * dt, 18) * dt;
        tcomp = asr(32'd81920000 - x01 - x02 - x03, 15);
        dt2 = asr(x01 + x02 + x03, 12);
        x11 = (c5 - k5) * dt2;
        x12 = asr(asr(c6 * dt2, 16) * dt2, 2);
        x13 = asr(x11 + x12, 10) + ((c4 + k4) << 4);
        x21 = asr((c8 + k8) * dt2, 10);
        x22 = asr(asr(c9 * dt2, 17) * dt2, 12);
        diff = x22 - x21;
        // magnitude by signed compare, sign from wrapped difference
        x23 = ($signed(x22) >= $signed(x21)) ? x22 - x21 : x21 - x22;
        k7c = c7 + k7;
        x24 = asr(x23, 11) * k7c;
        x25 = asr((x23 & 32'h7FF) * k7c, 11);
        if (diff[31])
            x26 = asr(32'd0 - x24 - x25, 11) + k7c;
        else
            x26 = asr(x24 + x25, 11) + k7c;
        pp1 = asr(({8'd0, rd.rp} - 32'd8388608) - x13, 3);
        pp2 = asr(x26, 11) * pp1;
        pp3 = asr((x26 & 32'h7FF) * pp1, 11);
        pp4 = asr(pp2 + pp3, 10);
        cf = asr(32'd2097152 + c12 * dt2, 3);
        x31 = asr(asr(cf * c10, 17) * pp4, 2);
        x32 = asr(asr(cf * c11, 15) * pp4, 18) * pp4;
        pcomp = asr(x31 + x32, 15) + pp4 + 32'd99880;
        res.pa = pcomp;
        res.centi = tcomp;
        return res;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: offers queued readings, idling at the configured rate
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid        <= 1'b0;
            raw_temperature <= '0;
            raw_pressure    <= '0;
        end else begin
            if (in_valid && in_ready) begin
                expected_comp.push_back(compensate('{raw_temperature, raw_pressure}));
            end
            if (!in_valid || in_ready) begin
                if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid        <= 1'b1;
                    raw_temperature <= pending_readings[0].rt;
                    raw_pressure    <= pending_readings[0].rp;
                    void'(pending_readings.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted in its own process
    initial begin
        hold_off = 1'b0;
        @(posedge hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        comp_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_comp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result pa=%h centi=%h", pressure_pa,
                                 temperature_centi);
                end else begin
                    want = expected_comp.pop_front();
                    if (want.pa !== pressure_pa || want.centi !== temperature_centi) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp pa=%h centi=%h got pa=%h centi=%h",
                                     want.pa, want.centi, pressure_pa, temperature_centi);
                    end
                end
            end
            // long hold-off lets the pipe fill and stall its input
            if (hold_off) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // cycle counter and timeout
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bptc_pkg::CFG_A:    cal_a    = val;
            bptc_pkg::CFG_B:    cal_b    = val;
            bptc_pkg::CFG_C:    cal_c    = val;
            bptc_pkg::CFG_LAST: cal_last = val[15:0];
            bptc_pkg::CFG_VAR:  variant  = val[0];
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [47:0] a, input logic [47:0] b,
                            input logic [47:0] c, input logic [47:0] last,
                            input logic [47:0] vsel);
        write_reg(bptc_pkg::CFG_A, a);
        write_reg(bptc_pkg::CFG_B, b);
        write_reg(bptc_pkg::CFG_C, c);
        write_reg(bptc_pkg::CFG_LAST, last);
        write_reg(bptc_pkg::CFG_VAR, vsel);
    endtask

    // wait for every queued reading to be taken and every result seen
    task automatic drain();
        while (pending_readings.size() > 0 || in_valid || expected_comp.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [23:0] rand24();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 24'h000000;
        if (k == 1) return 24'hFFFFFF;
        if (k < 6)  return 24'h800000 + 24'($urandom_range(200000)) - 24'd100000;
        return 24'($urandom());
    endfunction

    task automatic queue_random(input int n);
        repeat (n) pending_readings.push_back('{rand24(), rand24()});
    endtask

    initial begin
        // realistic calibration set with moderate coefficient values
        logic [47:0] typ_a, typ_b, typ_c;
        typ_a = 48'h9A40_6B23_3C15;
        typ_b = 48'h5A1E_7F33_2C4D;
        typ_c = 48'h3E29_1B47_2A12;
        rst_n = 1'b0;
        hold_go = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        cal_a = '0; cal_b = '0; cal_c = '0; cal_last = '0; variant = 1'b0;
        // sender 29 / receiver 53 for the first half
        send_idle_pct = 29; recv_idle_pct = 53;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset calibration, field extremes
        pending_readings.push_back('{24'h000000, 24'h000000});
        pending_readings.push_back('{24'hFFFFFF, 24'hFFFFFF});
        pending_readings.push_back('{24'h800000, 24'h800000});
        drain();

        // directed: all-ones calibration in both variants, wrap everywhere
        load_cal('1, '1, '1, '1, 48'd1);
        pending_readings.push_back('{24'h000000, 24'hFFFFFF});
        pending_readings.push_back('{24'hFFFFFF, 24'h000000});
        pending_readings.push_back('{24'h7FFFFF, 24'h800001});
        drain();
        load_cal('1, '1, '1, '1, 48'd0);
        pending_readings.push_back('{24'h000000, 24'hFFFFFF});
        pending_readings.push_back('{24'hFFFFFF, 24'h000000});
        pending_readings.push_back('{24'hA55A5A, 24'h5AA5A5});
        drain();

        // directed: typical coefficients, sweep temperature for curvature sign, then both inputs
        load_cal(typ_a, typ_b, typ_c, 48'h00A7, 48'd0);
        for (int i = 0; i < 8; i++)
            pending_readings.push_back('{24'h800000 + 24'(i * 24'h0C000) - 24'h30000,
                                         24'h7F0000});
        drain();
        load_cal(typ_a, typ_b, typ_c, 48'h3F58, 48'd1);
        for (int i = 0; i < 6; i++)
            pending_readings.push_back('{24'(i * 24'h2AAAAA), 24'hFFFFFF - 24'(i * 24'h222222)});
        drain();

        // random: sender 29 / receiver 53, long receiver hold-off in the middle
        load_cal(rand48(), rand48(), rand48(), rand48(), {47'd0, 1'b0});
        queue_random(100);
        hold_go = 1'b1;
        drain();
        load_cal(rand48(), rand48(), rand48(), rand48(), {47'd0, 1'b1});
        queue_random(100);
        drain();

        // random: sender 53 / receiver 29
        send_idle_pct = 53; recv_idle_pct = 29;
        load_cal(typ_a, typ_b, typ_c, rand48(), 48'd0);
        queue_random(100);
        drain();
        load_cal(rand48(), rand48(), rand48(), rand48(), rand48());
        queue_random(100);
        drain();

        // random: no idling on either side
        send_idle_pct = 0; recv_idle_pct = 0;
        load_cal(rand48(), rand48(), rand48(), rand48(), 48'd1);
        queue_random(100);
        drain();
        load_cal(48'd0, 48'd0, 48'd0, 48'd0, 48'd0);
        queue_random(100);
        drain();

        if (mismatches == 0 && expected_comp.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bptc_pkg.sv
rtl/bptc_coef.sv
rtl/bptc_datapath.sv
rtl/baro_pressure_temp_compensation.sv
rtl/bptc_checker.sv
tb/sv/tb_baro_pressure_temp_compensation.sv
